@@ hw/rtl/aip_pkg.sv @@
// ---------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and scale constants of the ASCII int64 parser.
// ---------------------------------------------------------------------------
package aip_pkg;

    localparam int MAX_HEX_DIGITS_DEF = 16;

    localparam logic [63:0] INT64_TOP = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] DEC_LIMIT = (INT64_TOP - 64'd9) / 64'd10;

    localparam logic [39:0] SCALE_ONE = 40'd1;
    localparam logic [39:0] SCALE_K   = 40'd1000;
    localparam logic [39:0] SCALE_M   = 40'd1000000;
    localparam logic [39:0] SCALE_G   = 40'd1000000000;
    localparam logic [39:0] SCALE_B   = 40'd1000000000000;

    localparam logic [63:0] LIMIT_K = INT64_TOP / {24'd0, SCALE_K};
    localparam logic [63:0] LIMIT_M = INT64_TOP / {24'd0, SCALE_M};
    localparam logic [63:0] LIMIT_G = INT64_TOP / {24'd0, SCALE_G};
    localparam logic [63:0] LIMIT_B = INT64_TOP / {24'd0, SCALE_B};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_K     = 8'h6b;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIGNED,
        PH_DEC,
        PH_HEX
    } aip_phase_t;

    typedef enum logic [2:0] {
        SC_NONE,
        SC_K,
        SC_M,
        SC_G,
        SC_B
    } aip_scale_t;

    typedef struct packed {
        logic [63:0] acc;
        aip_scale_t  sc;
        logic        neg;
        logic [1:0]  status;
        logic        consumed;
    } aip_job_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } aip_digit_t;

    function automatic aip_digit_t hex_digit(input logic [7:0] c);
        aip_digit_t d;
        d.valid = 1'b1;
        d.val   = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            d.val = 4'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            d.val = 4'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            d.val = 4'(c - CH_UA + 8'd10);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

    function automatic aip_scale_t scale_code(input logic [7:0] c);
        aip_scale_t s;
        case (c)
            CH_K:    s = SC_K;
            CH_M:    s = SC_M;
            CH_G:    s = SC_G;
            CH_B:    s = SC_B;
            default: s = SC_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [39:0] scale_factor(input aip_scale_t s);
        logic [39:0] f;
        case (s)
            SC_K:    f = SCALE_K;
            SC_M:    f = SCALE_M;
            SC_G:    f = SCALE_G;
            SC_B:    f = SCALE_B;
            default: f = SCALE_ONE;
        endcase
        return f;
    endfunction

    function automatic logic [63:0] scale_limit(input aip_scale_t s);
        logic [63:0] l;
        case (s)
            SC_K:    l = LIMIT_K;
            SC_M:    l = LIMIT_M;
            SC_G:    l = LIMIT_G;
            SC_B:    l = LIMIT_B;
            default: l = INT64_TOP;
        endcase
        return l;
    endfunction

endpackage

@@ hw/rtl/aip_if.sv @@
// ---------------------------------------------------------------------------
// aip_char_if / aip_result_if
// Valid/ready channels of the parser: characters in, parsed results out.
// ---------------------------------------------------------------------------
interface aip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface aip_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic        [1:0]  status;
    logic               consumed;

    modport source (output valid, output value, output status, output consumed, input ready);
    modport sink (input valid, input value, input status, input consumed, output ready);
endinterface

@@ hw/rtl/aip_scan.sv @@
// ---------------------------------------------------------------------------
// aip_scan
// Character state machine: skip, sign, hex/decimal digits, terminator decode.
// ---------------------------------------------------------------------------
module aip_scan
    import aip_pkg::*;
#(
    parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    aip_char_if.sink      chars,
    output logic          job_valid,
    input  logic          job_ready,
    output aip_job_t      job
);

    localparam int CntW = $clog2(MAX_HEX_DIGITS + 1);

    aip_phase_t        phase_reg, phase_next;
    logic [63:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;

    logic              accept;
    logic              is_space, is_minus, is_x, is_dec, dec_ovf, hex_full, scale_ovf;
    logic [3:0]        dec_val;
    aip_digit_t        hd;
    aip_scale_t        sc;
    logic [63:0]       acc_x10;
    logic              emit, fin;

    assign accept      = chars.valid && chars.ready;
    assign chars.ready = job_ready;

    assign is_space  = (chars.ch != 8'd0) && (chars.ch <= CH_SPACE);
    assign is_minus  = (chars.ch == CH_MINUS);
    assign is_x      = (chars.ch == CH_X);
    assign is_dec    = (chars.ch >= CH_0) && (chars.ch <= CH_9);
    assign dec_val   = 4'(chars.ch - CH_0);
    assign hd        = hex_digit(chars.ch);
    assign sc        = scale_code(chars.ch);
    assign dec_ovf   = (acc_reg > DEC_LIMIT);
    assign hex_full  = (cnt_reg == CntW'(MAX_HEX_DIGITS));
    assign scale_ovf = !acc_reg[63] && (acc_reg > scale_limit(sc));
    assign acc_x10   = (acc_reg << 3) + (acc_reg << 1) + {60'd0, dec_val};

    always_comb
    begin
        phase_next = PH_IDLE;
        case (phase_reg)
            PH_IDLE:
            begin
                if (is_space)
                    phase_next = PH_IDLE;
                else if (is_minus)
                    phase_next = PH_SIGNED;
                else if (is_x)
                    phase_next = PH_HEX;
                else if (is_dec)
                    phase_next = PH_DEC;
            end
            PH_SIGNED:
            begin
                if (is_x)
                    phase_next = PH_HEX;
                else if (is_dec)
                    phase_next = PH_DEC;
            end
            PH_DEC:
            begin
                if (is_dec && !dec_ovf)
                    phase_next = PH_DEC;
            end
            PH_HEX:
            begin
                if (hd.valid && !hex_full)
                    phase_next = PH_HEX;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        emit         = 1'b0;
        fin          = 1'b0;
        job.acc      = acc_reg;
        job.neg      = neg_reg;
        job.sc       = SC_NONE;
        job.status   = ST_FAIL;
        job.consumed = 1'b0;
        case (phase_reg)
            PH_IDLE, PH_SIGNED:
            begin
                if (phase_reg == PH_IDLE && is_space)
                begin
                end
                else if (phase_reg == PH_IDLE && is_minus)
                    neg_next = 1'b1;
                else if (is_x)
                begin
                    acc_next = 64'd0;
                    cnt_next = '0;
                end
                else if (is_dec)
                    acc_next = {60'd0, dec_val};
                else
                    emit = 1'b1;
            end
            PH_DEC:
            begin
                if (is_dec)
                begin
                    if (dec_ovf)
                        emit = 1'b1;
                    else
                        acc_next = acc_x10;
                end
                else
                    fin = 1'b1;
            end
            PH_HEX:
            begin
                if (hd.valid)
                begin
                    if (hex_full)
                        emit = 1'b1;
                    else
                    begin
                        acc_next = {acc_reg[59:0], hd.val};
                        cnt_next = cnt_reg + CntW'(1);
                    end
                end
                else if (cnt_reg == '0)
                    emit = 1'b1;
                else
                    fin = 1'b1;
            end
            default: emit = 1'b0;
        endcase
        if (fin)
        begin
            emit         = 1'b1;
            job.sc       = sc;
            job.status   = scale_ovf ? ST_SCALE : ST_OK;
            job.consumed = (sc != SC_NONE);
        end
        if (emit)
        begin
            acc_next = 64'd0;
            neg_next = 1'b0;
            cnt_next = '0;
        end
    end

    assign job_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/aip_scale.sv @@
// ---------------------------------------------------------------------------
// aip_scale
// Suffix multiply in 32-bit partial products, sign apply and result register.
// ---------------------------------------------------------------------------
module aip_scale
    import aip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  aip_job_t      job,
    aip_result_if.source  results
);

    logic               s1_valid_reg;
    aip_job_t           s1_reg;
    logic               s2_valid_reg;
    logic [63:0]        p0_reg;
    logic [31:0]        p12_reg;
    logic               s2_neg_reg;
    logic [1:0]         s2_status_reg;
    logic               s2_consumed_reg;
    logic               out_valid_reg;
    logic signed [63:0] value_reg;
    logic [1:0]         status_reg;
    logic               consumed_reg;

    logic               out_adv, s2_adv, s1_adv;
    logic [39:0]        f;
    logic [63:0]        p0;
    logic [31:0]        p1, p2;
    logic [63:0]        inv_mask, sum;

    assign out_adv   = !out_valid_reg || results.ready;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign job_ready = s1_adv;

    assign f  = scale_factor(s1_reg.sc);
    assign p0 = 64'(s1_reg.acc[31:0]) * 64'(f[31:0]);
    assign p1 = 32'(s1_reg.acc[63:32] * f[31:0]);
    assign p2 = 32'(s1_reg.acc[31:0] * {24'd0, f[39:32]});

    // -(a + b) = ~a + ~b + 2
    assign inv_mask = {64{s2_neg_reg}};
    assign sum = (p0_reg ^ inv_mask) + ({p12_reg, 32'd0} ^ inv_mask)
               + {62'd0, s2_neg_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= job_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            s1_reg <= job;
        if (s2_adv)
        begin
            p0_reg          <= p0;
            p12_reg         <= p1 + p2;
            s2_neg_reg      <= s1_reg.neg;
            s2_status_reg   <= s1_reg.status;
            s2_consumed_reg <= s1_reg.consumed;
        end
        if (out_adv)
        begin
            value_reg    <= (s2_status_reg == ST_OK) ? sum : 64'd0;
            status_reg   <= s2_status_reg;
            consumed_reg <= s2_consumed_reg;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.value    = value_reg;
    assign results.status   = status_reg;
    assign results.consumed = consumed_reg;

endmodule

@@ hw/rtl/ascii_int64_parser.sv @@
// ---------------------------------------------------------------------------
// ascii_int64_parser
// Streaming ASCII to signed 64-bit integer parser with k/M/G/B suffixes.
// ---------------------------------------------------------------------------
// Usage:
//   chars   : one character per transfer; 0 ends the string. Bytes 1..32
//             before the number are skipped, then optional '-', optional
//             'x' for hex, then digits.
//   results : one transfer per number (value, status, consumed), issued on
//             the character that ends or fails the number.
//   Throughput: one character per cycle while the result pipeline takes
//   jobs, set by the registered update of the character state machine.
//   Pipeline: the job of the ending character is registered in s1, its
//   suffix partial products in s2, then sum and sign in the output reg.
//   Reset: parser returns to idle with a zero accumulator, the result
//   pipeline empties.
//   Stall: when results.ready stays low, the pipeline fills its empty stages
//   and then holds chars.ready low until the output register drains.
// ---------------------------------------------------------------------------
module ascii_int64_parser
    import aip_pkg::*;
#(
    parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    aip_char_if.sink     chars,
    aip_result_if.source results
);

    logic     job_valid;
    logic     job_ready;
    aip_job_t job;

    aip_scan #(
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    aip_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .results   (results)
    );

endmodule

@@ hw/rtl/aip_checker.sv @@
// ---------------------------------------------------------------------------
// aip_checker
// Port-level checks of the parser's result channel, bound to the top level.
// ---------------------------------------------------------------------------
module aip_checker
    import aip_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] value,
    input logic [1:0]  status,
    input logic        consumed
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status)
                                    && $stable(consumed))
        else $error("result dropped or changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value == 64'd0)
        else $error("nonzero value with error status");

    a_fail_cons: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FAIL |-> !consumed)
        else $error("failed parse marked consumed");

    a_scale_cons: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SCALE |-> consumed)
        else $error("scale overflow without consumed suffix");

endmodule

bind ascii_int64_parser aip_checker u_aip_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .value     (results.value),
    .status    (results.status),
    .consumed  (results.consumed)
);
